// File: rtl/core/lnedit_pkg.sv
// Shared types and constants of the line editor with masked echo.
package lnedit_pkg;

	// Default capacity of the line store
	localparam int LINE_CAP_DEF = 63;

	// Width of one stored character (7-bit ASCII)
	localparam int CHAR_W = 7;

	// Width of a line length
	localparam int LEN_W = 6;

	// Result kinds
	localparam logic [1:0] KIND_ECHO = 2'd0;
	localparam logic [1:0] KIND_BYTE = 2'd1;
	localparam logic [1:0] KIND_END  = 2'd2;

	// Character codes
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_LF    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_DEL   = 8'd127;

	// Register indexes on the configuration port
	localparam logic REG_MASK_ECHO = 1'b0;
	localparam logic REG_MAX_CHARS = 1'b1;

	// Control strobes from the sequencer to the line store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} store_ctl_t;

endpackage

// File: rtl/core/lnedit_store.sv
// Line store: one write port, one read port with registered read data.
module lnedit_store #(
	parameter int DEPTH = lnedit_pkg::LINE_CAP_DEF,
	parameter int AW    = 6
) (
	input  logic                            clk,
	input  lnedit_pkg::store_ctl_t          ctl,
	input  logic [AW-1:0]                   waddr,
	input  logic [lnedit_pkg::CHAR_W-1:0]   wdata,
	input  logic [AW-1:0]                   raddr,
	output logic [lnedit_pkg::CHAR_W-1:0]   rdata
);

	logic [lnedit_pkg::CHAR_W-1:0] mem [DEPTH];
	logic [lnedit_pkg::CHAR_W-1:0] rdata_q;

	// Store a character
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	// Read one entry; hold the data while no read is issued
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/line_editor_with_masked_echo_top.sv
// Top level of the line editor: sequencer, registers and output stage.
//
//  port group   direction  handshake                contents
//  in_*         in         in_valid / in_ready      in_char
//  out          out        out_valid / out_ready    kind, data_byte, line_length, last
//  APB          in/out     psel, penable / pready   mask_echo (0x0), max_chars (0x4)
//
// A printable byte frees the input in the same cycle that its echo is offered; an
// ignored byte frees it with no echo. Backspace echoes backspace, space, backspace. A
// non-empty line end gives each stored byte and then the line end, an empty one
// only the line end; the single store read port gives a byte a cycle unless stalled.
// Reset clears the fill count and registers; the line store itself is not cleared.
// A stalled output holds the sequencer; one input item waits in its own register.
module line_editor_with_masked_echo_top #(
	parameter int LINE_CAP = lnedit_pkg::LINE_CAP_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_char,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [5:0]  line_length,
	output logic        last,
	// configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int AW = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;
	localparam logic [lnedit_pkg::LEN_W-1:0] CAP_LEN = lnedit_pkg::LEN_W'(LINE_CAP);

	typedef enum logic [2:0] {
		S_IDLE,
		S_BS_SPACE,
		S_BS_TAIL,
		S_DRAIN,
		S_END
	} state_t;

	state_t                              state_q;
	logic                                pend_q;
	logic [7:0]                          char_q;
	logic [lnedit_pkg::LEN_W-1:0]        fill_q;
	logic [lnedit_pkg::LEN_W-1:0]        rd_idx_q;
	logic                                mask_q;
	logic [lnedit_pkg::LEN_W-1:0]        max_chars_q;
	logic                                ov_q;
	logic [1:0]                          kind_q;
	logic [7:0]                          data_q;
	logic [lnedit_pkg::LEN_W-1:0]        len_q;
	logic                                last_q;

	logic                                load;
	logic                                emit;
	logic                                is_eol;
	logic                                is_bs;
	logic                                is_print;
	logic [lnedit_pkg::LEN_W-1:0]        limit;
	logic [lnedit_pkg::LEN_W-1:0]        nxt_idx;
	logic                                cfg_wr;
	lnedit_pkg::store_ctl_t              store_ctl;
	logic [AW-1:0]                       raddr;
	logic [lnedit_pkg::CHAR_W-1:0]       rdata;

	// Decode the waiting item and the output stage
	assign load     = !ov_q || out_ready;
	assign is_eol   = (char_q == lnedit_pkg::CH_LF) || (char_q == lnedit_pkg::CH_CR);
	assign is_bs    = (char_q == lnedit_pkg::CH_BS);
	assign is_print = (char_q >= lnedit_pkg::CH_SPACE) && (char_q < lnedit_pkg::CH_DEL);
	assign limit    = (max_chars_q < CAP_LEN) ? max_chars_q : CAP_LEN;
	assign nxt_idx  = rd_idx_q + 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;

	// A new result enters the output stage this cycle
	assign emit = load && ((state_q != S_IDLE)
		|| (pend_q && ((is_eol && (fill_q == '0)) || (is_bs && (fill_q != '0))
			|| (is_print && (fill_q < limit)))));

	// Store strobes: write on a stored byte, read at a non-empty line end and ahead while draining
	always_comb begin
		store_ctl.wr_en = (state_q == S_IDLE) && pend_q && load && is_print && (fill_q < limit);
		store_ctl.rd_en = ((state_q == S_IDLE) && pend_q && load && is_eol && (fill_q != '0))
			|| ((state_q == S_DRAIN) && load && (nxt_idx < fill_q));
		raddr = (state_q == S_DRAIN) ? nxt_idx[AW-1:0] : '0;
	end

	lnedit_store #(
		.DEPTH (LINE_CAP),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.ctl   (store_ctl),
		.waddr (fill_q[AW-1:0]),
		.wdata (char_q[lnedit_pkg::CHAR_W-1:0]),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Sequencer, registers and output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pend_q      <= 1'b0;
			char_q      <= '0;
			fill_q      <= '0;
			rd_idx_q    <= '0;
			mask_q      <= 1'b0;
			max_chars_q <= 6'd63;
			ov_q        <= 1'b0;
			kind_q      <= lnedit_pkg::KIND_ECHO;
			data_q      <= '0;
			len_q       <= '0;
			last_q      <= 1'b0;
		end else begin
			// drop a result once taken, unless a new one replaces it
			if (ov_q && out_ready && !emit) begin
				ov_q <= 1'b0;
			end

			// take configuration writes
			if (cfg_wr) begin
				unique case (paddr[2])
					lnedit_pkg::REG_MASK_ECHO: mask_q      <= pwdata[0];
					lnedit_pkg::REG_MAX_CHARS: max_chars_q <= pwdata[5:0];
					default: ;
				endcase
			end

			// hold an accepted item
			if (in_valid && in_ready) begin
				char_q <= in_char;
				pend_q <= 1'b1;
			end

			unique case (state_q)
				S_IDLE: begin
					if (pend_q && load) begin
						if (is_eol) begin
							if (fill_q == '0) begin
								ov_q   <= 1'b1;
								kind_q <= lnedit_pkg::KIND_END;
								data_q <= lnedit_pkg::CH_LF;
								len_q  <= '0;
								last_q <= 1'b1;
								pend_q <= 1'b0;
							end else begin
								rd_idx_q <= '0;
								state_q  <= S_DRAIN;
							end
						end else if (is_bs) begin
							if (fill_q != '0) begin
								fill_q  <= fill_q - 1'b1;
								ov_q    <= 1'b1;
								kind_q  <= lnedit_pkg::KIND_ECHO;
								data_q  <= lnedit_pkg::CH_BS;
								len_q   <= '0;
								last_q  <= 1'b0;
								state_q <= S_BS_SPACE;
							end else begin
								pend_q <= 1'b0;
							end
						end else if (is_print && (fill_q < limit)) begin
							fill_q <= fill_q + 1'b1;
							ov_q   <= 1'b1;
							kind_q <= lnedit_pkg::KIND_ECHO;
							data_q <= mask_q ? lnedit_pkg::CH_STAR : char_q;
							len_q  <= '0;
							last_q <= 1'b1;
							pend_q <= 1'b0;
						end else begin
							pend_q <= 1'b0;
						end
					end
				end
				S_BS_SPACE: begin
					if (load) begin
						ov_q    <= 1'b1;
						kind_q  <= lnedit_pkg::KIND_ECHO;
						data_q  <= lnedit_pkg::CH_SPACE;
						len_q   <= '0;
						last_q  <= 1'b0;
						state_q <= S_BS_TAIL;
					end
				end
				S_BS_TAIL: begin
					if (load) begin
						ov_q    <= 1'b1;
						kind_q  <= lnedit_pkg::KIND_ECHO;
						data_q  <= lnedit_pkg::CH_BS;
						len_q   <= '0;
						last_q  <= 1'b1;
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_DRAIN: begin
					if (load) begin
						ov_q     <= 1'b1;
						kind_q   <= lnedit_pkg::KIND_BYTE;
						data_q   <= {1'b0, rdata};
						len_q    <= '0;
						last_q   <= 1'b0;
						rd_idx_q <= nxt_idx;
						if (nxt_idx == fill_q) begin
							state_q <= S_END;
						end
					end
				end
				S_END: begin
					if (load) begin
						ov_q    <= 1'b1;
						kind_q  <= lnedit_pkg::KIND_END;
						data_q  <= lnedit_pkg::CH_LF;
						len_q   <= fill_q;
						last_q  <= 1'b1;
						fill_q  <= '0;
						pend_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Drive the ports
	assign in_ready    = !pend_q;
	assign out_valid   = ov_q;
	assign kind        = kind_q;
	assign data_byte   = data_q;
	assign line_length = len_q;
	assign last        = last_q;
	assign pready      = 1'b1;

	// Read back the registers
	always_comb begin
		prdata = '0;
		unique case (paddr[2])
			lnedit_pkg::REG_MASK_ECHO: prdata = {31'd0, mask_q};
			lnedit_pkg::REG_MAX_CHARS: prdata = {26'd0, max_chars_q};
			default: prdata = '0;
		endcase
	end

	// The line never holds more than the store can take
	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CAP_LEN)
		else $error("fill count beyond line capacity");

	// Work past the idle state always belongs to a held item
	a_busy_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != S_IDLE |-> pend_q)
		else $error("sequencer busy without a held item");

	// A line end echoes a newline and closes the item
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		ov_q && (kind_q == lnedit_pkg::KIND_END) |-> (data_q == lnedit_pkg::CH_LF) && last_q)
		else $error("malformed line end result");

	// Issuing the line end empties the line
	a_end_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_END) && load |=> (fill_q == '0) && (state_q == S_IDLE))
		else $error("line not cleared after line end");

	// Draining never reads past the stored bytes
	a_drain_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DRAIN |-> rd_idx_q < fill_q)
		else $error("drain index beyond fill count");

endmodule
